[design/exprtok_pkg.sv]
package exprtok_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] CLS_IDENT  = 3'd0;
	localparam logic [2:0] CLS_NUMBER = 3'd1;
	localparam logic [2:0] CLS_OPER   = 3'd2;
	localparam logic [2:0] CLS_LPAREN = 3'd3;
	localparam logic [2:0] CLS_RPAREN = 3'd4;
	localparam logic [2:0] CLS_EOE    = 3'd5;
	localparam logic [2:0] CLS_ERROR  = 3'd6;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_E_LOWER    = 8'h65;
	localparam logic [7:0] CH_E_UPPER    = 8'h45;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_CARET      = 8'h5E;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	typedef struct packed {
		logic [7:0] out_char;
		logic [2:0] token_class;
		logic       token_end;
		logic       last;
	} res_t;

	// one queue entry: the results of one input transaction
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return is_upper(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			(c == CH_UNDERSCORE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
			(c == CH_SLASH) || (c == CH_CARET);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return is_upper(c) ? c + CASE_OFFSET : c;
	endfunction

endpackage

[design/exprtok_front.sv]
module exprtok_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            char_code,
	input  logic                  end_of_text,
	output logic                  push,
	output exprtok_pkg::entry_t   entry
);

	typedef enum logic [9:0] {
		M_IDLE  = 10'b0000000001,
		M_IDENT = 10'b0000000010,
		M_ZERO  = 10'b0000000100,
		M_INT   = 10'b0000001000,
		M_DOT   = 10'b0000010000,
		M_FRAC  = 10'b0000100000,
		M_EXP   = 10'b0001000000,
		M_ESIGN = 10'b0010000000,
		M_EDIG  = 10'b0100000000,
		M_ERR   = 10'b1000000000
	} mode_t;

	mode_t      mode_q, nxt_mode;
	logic [7:0] held_q, nxt_held;

	logic              st_put, st_hold;
	logic [7:0]        st_char;
	mode_t             st_mode;
	exprtok_pkg::res_t st_res;

	logic       do_extend, do_fail, do_finish, do_start;
	logic [7:0] ext_char;
	mode_t      ext_mode;
	logic [2:0] held_cls;
	logic       n_any, n_two;
	exprtok_pkg::res_t r0, r1;

	// token start from between tokens
	always_comb begin
		st_put  = 1'b0;
		st_hold = 1'b0;
		st_char = char_code;
		st_mode = M_IDLE;
		st_res  = '{out_char: char_code, token_class: exprtok_pkg::CLS_ERROR,
			token_end: 1'b1, last: 1'b0};
		priority if (exprtok_pkg::is_space(char_code)) begin
			st_mode = M_IDLE;
		end else if (exprtok_pkg::is_digit(char_code)) begin
			st_hold = 1'b1;
			st_mode = (char_code == exprtok_pkg::CH_ZERO) ? M_ZERO : M_INT;
		end else if (exprtok_pkg::is_ident_start(char_code)) begin
			st_hold = 1'b1;
			st_char = exprtok_pkg::to_lower(char_code);
			st_mode = M_IDENT;
		end else if (char_code == exprtok_pkg::CH_LPAREN) begin
			st_put = 1'b1;
			st_res.token_class = exprtok_pkg::CLS_LPAREN;
		end else if (char_code == exprtok_pkg::CH_RPAREN) begin
			st_put = 1'b1;
			st_res.token_class = exprtok_pkg::CLS_RPAREN;
		end else if (exprtok_pkg::is_oper(char_code)) begin
			st_put = 1'b1;
			st_res.token_class = exprtok_pkg::CLS_OPER;
		end else begin
			st_put  = 1'b1;
			st_mode = M_ERR;
		end
	end

	always_comb begin
		do_extend = 1'b0;
		do_fail   = 1'b0;
		do_finish = 1'b0;
		do_start  = 1'b0;
		ext_char  = char_code;
		ext_mode  = mode_q;
		unique case (mode_q)
			M_ERR: begin
			end
			M_IDENT: begin
				if (exprtok_pkg::is_ident_start(char_code) ||
						exprtok_pkg::is_digit(char_code)) begin
					do_extend = 1'b1;
					ext_char  = exprtok_pkg::to_lower(char_code);
				end else begin
					do_finish = 1'b1;
				end
			end
			M_ZERO, M_INT, M_FRAC: begin
				priority if (exprtok_pkg::is_digit(char_code)) begin
					if (mode_q == M_ZERO) begin
						do_fail = 1'b1;
					end else begin
						do_extend = 1'b1;
					end
				end else if (char_code == exprtok_pkg::CH_DOT && mode_q != M_FRAC) begin
					do_extend = 1'b1;
					ext_mode  = M_DOT;
				end else if (char_code == exprtok_pkg::CH_E_LOWER ||
						char_code == exprtok_pkg::CH_E_UPPER) begin
					do_extend = 1'b1;
					ext_char  = exprtok_pkg::CH_E_LOWER;
					ext_mode  = M_EXP;
				end else if (exprtok_pkg::is_ident_start(char_code)) begin
					do_fail = 1'b1;
				end else begin
					do_finish = 1'b1;
				end
			end
			M_DOT: begin
				ext_mode  = M_FRAC;
				do_extend = exprtok_pkg::is_digit(char_code);
				do_fail   = !exprtok_pkg::is_digit(char_code);
			end
			M_EXP: begin
				priority if (char_code == exprtok_pkg::CH_PLUS ||
						char_code == exprtok_pkg::CH_MINUS) begin
					do_extend = 1'b1;
					ext_mode  = M_ESIGN;
				end else if (exprtok_pkg::is_digit(char_code)) begin
					do_extend = 1'b1;
					ext_mode  = M_EDIG;
				end else begin
					do_fail = 1'b1;
				end
			end
			M_ESIGN: begin
				ext_mode  = M_EDIG;
				do_extend = exprtok_pkg::is_digit(char_code);
				do_fail   = !exprtok_pkg::is_digit(char_code);
			end
			M_EDIG: begin
				priority if (exprtok_pkg::is_digit(char_code)) begin
					do_extend = 1'b1;
				end else if (exprtok_pkg::is_ident_start(char_code)) begin
					do_fail = 1'b1;
				end else begin
					do_finish = 1'b1;
				end
			end
			default: begin
				do_start = 1'b1;
			end
		endcase
	end

	assign held_cls = (mode_q == M_IDENT) ? exprtok_pkg::CLS_IDENT : exprtok_pkg::CLS_NUMBER;

	always_comb begin
		nxt_mode = mode_q;
		nxt_held = held_q;
		n_any    = 1'b0;
		n_two    = 1'b0;
		r0 = '{out_char: held_q, token_class: held_cls, token_end: 1'b1, last: 1'b0};
		r1 = '{out_char: 8'h00, token_class: exprtok_pkg::CLS_EOE, token_end: 1'b1,
			last: 1'b1};
		if (end_of_text) begin
			nxt_mode = M_IDLE;
			nxt_held = 8'h00;
			n_any    = 1'b1;
			priority if (mode_q == M_DOT || mode_q == M_EXP || mode_q == M_ESIGN) begin
				n_two = 1'b1;
				r0 = '{out_char: 8'h00, token_class: exprtok_pkg::CLS_ERROR,
					token_end: 1'b1, last: 1'b0};
			end else if (mode_q == M_IDENT || mode_q == M_ZERO || mode_q == M_INT ||
					mode_q == M_FRAC || mode_q == M_EDIG) begin
				n_two = 1'b1;
			end else begin
				r0 = r1;
			end
		end else if (do_extend) begin
			n_any = 1'b1;
			r0.token_end = 1'b0;
			nxt_held = ext_char;
			nxt_mode = ext_mode;
		end else if (do_fail) begin
			n_any = 1'b1;
			r0 = '{out_char: char_code, token_class: exprtok_pkg::CLS_ERROR,
				token_end: 1'b1, last: 1'b0};
			nxt_held = 8'h00;
			nxt_mode = M_ERR;
		end else if (do_finish) begin
			n_any = 1'b1;
			n_two = st_put;
			r1 = st_res;
			nxt_held = st_hold ? st_char : 8'h00;
			nxt_mode = st_mode;
		end else if (do_start) begin
			n_any = st_put;
			r0 = st_res;
			nxt_held = st_hold ? st_char : 8'h00;
			nxt_mode = st_mode;
		end
		r0.last = !n_two;
		r1.last = 1'b1;
	end

	assign push  = accept && n_any;
	assign entry = '{two: n_two, r0: r0, r1: r1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= 8'h00;
		end else if (accept) begin
			mode_q <= nxt_mode;
			held_q <= nxt_held;
		end
	end

endmodule

[design/exprtok_queue.sv]
module exprtok_queue #(
	parameter int DEPTH = exprtok_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  exprtok_pkg::entry_t   wr_entry,
	input  logic                  pop,
	output exprtok_pkg::entry_t   rd_entry,
	output exprtok_pkg::q_stat_t  stat
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	exprtok_pkg::entry_t slots_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.nonempty = (count_q != '0);
	assign do_push  = push && !stat.full;
	assign do_pop   = pop && stat.nonempty;
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/exprtok_back.sv]
module exprtok_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  exprtok_pkg::entry_t   entry,
	input  exprtok_pkg::q_stat_t  stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output exprtok_pkg::res_t     out_res
);

	exprtok_pkg::entry_t ent_q;
	logic valid_q, sel_q;
	logic advance, done;

	assign advance   = valid_q && out_ready;
	assign done      = advance && (sel_q || !ent_q.two);
	assign pop       = stat.nonempty && (!valid_q || done);
	assign out_valid = valid_q;
	assign out_res   = sel_q ? ent_q.r1 : ent_q.r0;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
			sel_q   <= 1'b0;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (advance) begin
			sel_q <= 1'b1;
		end
	end

endmodule

[design/expression_tokenizer.sv]
// Streaming lexer for arithmetic expressions. One ASCII character (or an end-of-text mark)
// goes in per transaction; each token character comes out once, tagged with its class and an
// end-of-token flag, identifiers lowercased and an exponent mark as 'e'. The last character of
// an identifier or number is held until the next character shows where the token ends. A
// character is accepted every cycle while the result queue has room; the output register
// issues one result per cycle while the consumer is ready, so a character that yields two
// results (a finished token plus a single-character token, or a flush at end of text) takes
// the output for both in turn. The first result passes through the queue and then the output
// register before it is presented. After an error result further characters give nothing
// until end of text; the consumer drops the partial token.
module expression_tokenizer #(
	parameter int QUEUE_DEPTH = exprtok_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic [0:0] s_tuser,   // [0] end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic [3:0] m_tuser,   // [2:0] token_class, [3] token_end
	output logic       m_tlast
);

	exprtok_pkg::entry_t  wr_entry, rd_entry;
	exprtok_pkg::q_stat_t stat;
	exprtok_pkg::res_t    res;
	logic accept, push, pop;

	assign s_tready = !stat.full;
	assign accept   = s_tvalid && s_tready;

	exprtok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (s_tdata),
		.end_of_text(s_tuser[0]),
		.push       (push),
		.entry      (wr_entry)
	);

	exprtok_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(wr_entry),
		.pop     (pop),
		.rd_entry(rd_entry),
		.stat    (stat)
	);

	exprtok_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.entry    (rd_entry),
		.stat     (stat),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = res.out_char;
	assign m_tuser = {res.token_end, res.token_class};
	assign m_tlast = res.last;

	a_eoe_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == exprtok_pkg::CLS_EOE |-> m_tlast && m_tuser[3])
		else $error("end result not final");

	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == exprtok_pkg::CLS_ERROR |-> m_tuser[3])
		else $error("error result without token end");

	a_first_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser[2:0] == exprtok_pkg::CLS_IDENT ||
			m_tuser[2:0] == exprtok_pkg::CLS_NUMBER ||
			m_tuser[2:0] == exprtok_pkg::CLS_ERROR)
		else $error("unexpected class in leading result");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("queue push while full");

endmodule
